// ----- sv/pidc_pkg.sv -----
// Shared types, codes and constants of the I/O port decoder with cassette interface.
// No dependencies; every other file of the block but pidc_ram imports this package.
package pidc_pkg;

   // Default sizes handed to the top level parameters
   localparam int VRAM_DEPTH_DEF = 8192;
   localparam int KEY_ROWS_DEF   = 10;

   // Beat kinds on the request side
   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_READ    = 2'd1;
   localparam logic [1:0] CMD_KEY_ROW = 2'd2;

   // Device select codes on the response side
   localparam logic [2:0] DEV_LOCAL     = 3'd0;
   localparam logic [2:0] DEV_VDP0      = 3'd1;
   localparam logic [2:0] DEV_VDP1      = 3'd2;
   localparam logic [2:0] DEV_PSG_SEL   = 3'd3;
   localparam logic [2:0] DEV_PSG_WRITE = 3'd4;
   localparam logic [2:0] DEV_PSG_READ  = 3'd5;

   // Configuration register indexes
   localparam logic [1:0] CSR_TAPE_STOPPED = 2'd0;
   localparam logic [1:0] CSR_SHORT_TONE   = 2'd1;
   localparam logic [1:0] CSR_ZERO_PERIOD  = 2'd2;
   localparam logic [1:0] CSR_ONE_PERIOD   = 2'd3;

   localparam logic [15:0] SHORT_TONE_RST  = 16'd1824;  // 57*32
   localparam logic [15:0] ZERO_PERIOD_RST = 16'd1641;
   localparam logic [15:0] ONE_PERIOD_RST  = 16'd2188;

   // Port decode masks and matches
   localparam logic [15:0] PAGE_MASK     = 16'hE000;
   localparam logic [15:0] PAGE_VRAM     = 16'h0000;
   localparam logic [15:0] PAGE_IPL      = 16'hA000;
   localparam logic [15:0] PAGE_MODE     = 16'h2000;
   localparam logic [15:0] PAGE_MOTOR    = 16'h6000;
   localparam logic [15:0] VDP_MASK      = 16'hD860;
   localparam logic [15:0] PSG_MASK      = 16'hFFFE;
   localparam logic [15:0] PSG_PORT      = 16'h4000;
   localparam logic [15:0] KEY_PORT_BASE = 16'h8000;
   localparam logic [15:0] KEY_PORT_LAST = 16'h8009;

   localparam logic [7:0] KEY_ROW_RST    = 8'hFF;
   localparam logic [7:0] STATUS_BASE    = 8'h1F;
   localparam logic [7:0] STATUS_TAPE    = 8'h80;
   localparam logic [7:0] STATUS_MOTOR   = 8'h40;
   localparam logic [7:0] PSG_STATUS_REG = 8'd14;
   localparam logic [7:0] MOTOR_BIT      = 8'h02;

   typedef struct packed {
      logic        tape_stopped;
      logic [15:0] short_tone;
      logic [15:0] zero_period;
      logic [15:0] one_period;
   } cfg_type;

endpackage

// ----- sv/port_io_decoder_cassette.sv -----
// Top level of the I/O port decoder with cassette interface: decode, latches, VRAM, output.
// Depends on pidc_pkg, pidc_ram and pidc_tape.
//
//   channel   dir  handshake              contents
//   req_*     in   req_tvalid/req_tready  tuser command, tdata port access fields
//   rsp_*     out  rsp_tvalid/rsp_tready  tuser device select, tdata result fields
//   csr_*     in   csr_wr_en              register index and write data
//
// One beat is accepted per cycle while the pipeline is not held; a response passes
// the pending stage, which merges the registered VRAM read, then the output register.
// After reset a clearing pass writes zero to every VRAM entry with req_tready low;
// configuration writes are taken throughout.
// A stalled response holds the pipeline; the request side stops only when both
// the pending stage and the output register are full.
module port_io_decoder_cassette
   import pidc_pkg::*;
#(
   parameter int VRAM_DEPTH = VRAM_DEPTH_DEF,
   parameter int KEY_ROWS   = KEY_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [1:0]  req_tuser,  // [1:0] command
   input  logic [63:0] req_tdata,  // port[15:0], write_data[23:16], key_row[27:24],
                                   // cycle_now[59:28], tape_bit[60], zero[63:61]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [2:0]  rsp_tuser,  // [2:0] device_select
   output logic [23:0] rsp_tdata,  // read_data[7:0], tape_bit_taken[8], ipl_enabled[9],
                                   // graphics_mode[17:10], motor_on[18], zero[23:19]
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   localparam int VRAM_AW = $clog2(VRAM_DEPTH);
   localparam logic [15:0] DEPTH_X1 = 16'(VRAM_DEPTH);
   localparam logic [15:0] DEPTH_X2 = 16'(VRAM_DEPTH * 2);
   localparam logic [15:0] DEPTH_X4 = 16'(VRAM_DEPTH * 4);
   localparam logic [VRAM_AW-1:0] VRAM_LAST = VRAM_AW'(VRAM_DEPTH - 1);

   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] dev;
      logic       taken;
      logic       ipl;
      logic [7:0] mode;
      logic       motor;
   } result_type;

   // Request fields
   logic [1:0]  cmd;
   logic [15:0] port;
   logic [7:0]  wdata;
   logic [3:0]  key_row;
   logic [31:0] cycle_now;
   logic        tape_bit;

   assign cmd       = req_tuser;
   assign port      = req_tdata[15:0];
   assign wdata     = req_tdata[23:16];
   assign key_row   = req_tdata[27:24];
   assign cycle_now = req_tdata[59:28];
   assign tape_bit  = req_tdata[60];

   // Configuration
   cfg_type cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.tape_stopped <= 1'b0;
         cfg_ff.short_tone   <= SHORT_TONE_RST;
         cfg_ff.zero_period  <= ZERO_PERIOD_RST;
         cfg_ff.one_period   <= ONE_PERIOD_RST;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_TAPE_STOPPED: cfg_ff.tape_stopped <= csr_wdata[0];
            CSR_SHORT_TONE:   cfg_ff.short_tone   <= csr_wdata;
            CSR_ZERO_PERIOD:  cfg_ff.zero_period  <= csr_wdata;
            CSR_ONE_PERIOD:   cfg_ff.one_period   <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Small state
   logic       ipl_ff, ipl_in;
   logic [7:0] mode_ff, mode_in;
   logic       motor_ff, motor_in;
   logic       pulse_ff, pulse_in;
   logic [7:0] psg_ff, psg_in;
   logic [7:0] key_ff [KEY_ROWS];
   logic [7:0] key_in [KEY_ROWS];

   // VRAM clearing pass
   logic               clr_active_ff;
   logic [VRAM_AW-1:0] clr_addr_ff;

   // Pipeline
   logic       s1_valid_ff;
   result_type s1_ff, s1_in;
   logic       s1_use_ram_ff, use_ram;
   logic       rsp_valid_ff;
   result_type rsp_ff, rsp_in;

   logic acc;
   logic out_load;

   // Decode helpers
   logic               is_vram, is_ipl, is_mode, is_vdp, is_motor, is_psg, is_key;
   logic [15:0]        vram_off;
   logic [VRAM_AW-1:0] vram_idx;
   logic [7:0]         key_val;
   logic [7:0]         rd;
   logic [2:0]         dev;
   logic               ram_we, ram_re;
   logic               tape_sample, tape_level, tape_taken;
   logic [7:0]         ram_rdata;

   assign out_load   = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !clr_active_ff && (!s1_valid_ff || out_load);
   assign acc        = req_tvalid && req_tready;

   always_comb begin
      is_vram  = (port & PAGE_MASK) == PAGE_VRAM;
      is_ipl   = (port & PAGE_MASK) == PAGE_IPL;
      is_mode  = (port & PAGE_MASK) == PAGE_MODE;
      is_vdp   = (port & VDP_MASK) == VDP_MASK;
      is_motor = (port & PAGE_MASK) == PAGE_MOTOR;
      is_psg   = (port & PSG_MASK) == PSG_PORT;
      is_key   = port >= KEY_PORT_BASE && port <= KEY_PORT_LAST;

      // wrap the VRAM offset: the page is below 8 KB and the depth at least 1 KB
      vram_off = {3'd0, port[12:0]};
      if (vram_off >= DEPTH_X4) begin
         vram_off = vram_off - DEPTH_X4;
      end
      if (vram_off >= DEPTH_X2) begin
         vram_off = vram_off - DEPTH_X2;
      end
      if (vram_off >= DEPTH_X1) begin
         vram_off = vram_off - DEPTH_X1;
      end
      vram_idx = vram_off[VRAM_AW-1:0];

      key_val = KEY_ROW_RST;
      for (int i = 0; i < KEY_ROWS; i++) begin
         if (port[3:0] == 4'(i)) begin
            key_val = key_ff[i];
         end
      end
   end

   always_comb begin
      ipl_in      = ipl_ff;
      mode_in     = mode_ff;
      motor_in    = motor_ff;
      pulse_in    = pulse_ff;
      psg_in      = psg_ff;
      key_in      = key_ff;
      rd          = 8'd0;
      dev         = DEV_LOCAL;
      use_ram     = 1'b0;
      ram_we      = 1'b0;
      ram_re      = 1'b0;
      tape_sample = 1'b0;

      if (acc) begin
         unique case (cmd)
            CMD_WRITE: begin
               if (is_vram) begin
                  ram_we = 1'b1;
               end else if (is_ipl) begin
                  ipl_in = !ipl_ff;
               end else if (is_mode) begin
                  mode_in = wdata;
               end else if (is_vdp) begin
                  dev = port[0] ? DEV_VDP1 : DEV_VDP0;
               end else if (is_motor) begin
                  // toggle the motor on the falling edge of bit 1
                  if (!cfg_ff.tape_stopped) begin
                     if ((wdata & MOTOR_BIT) != 8'd0) begin
                        pulse_in = 1'b1;
                     end else if (pulse_ff) begin
                        pulse_in = 1'b0;
                        motor_in = !motor_ff;
                     end
                  end
               end else if (is_psg) begin
                  if (port[0]) begin
                     dev = DEV_PSG_WRITE;
                  end else begin
                     psg_in = wdata;
                     dev    = DEV_PSG_SEL;
                  end
               end
            end
            CMD_READ: begin
               if (is_key) begin
                  rd = key_val;
               end else if (is_ipl) begin
                  ipl_in = !ipl_ff;
               end else if (is_mode) begin
                  rd = mode_ff;
               end else if (is_vram) begin
                  ram_re  = 1'b1;
                  use_ram = 1'b1;
               end else if (is_vdp) begin
                  dev = port[0] ? DEV_VDP1 : DEV_VDP0;
               end else if (is_psg) begin
                  if (!port[0]) begin
                     rd = STATUS_BASE;
                  end else if (psg_ff != PSG_STATUS_REG) begin
                     dev = DEV_PSG_READ;
                  end else if (motor_ff) begin
                     tape_sample = 1'b1;
                     rd = tape_level ? (STATUS_BASE | STATUS_TAPE) : STATUS_BASE;
                  end else begin
                     rd = STATUS_BASE | STATUS_MOTOR;
                  end
               end
            end
            CMD_KEY_ROW: begin
               for (int i = 0; i < KEY_ROWS; i++) begin
                  if (key_row == 4'(i)) begin
                     key_in[i] = wdata;
                  end
               end
            end
            default: ;
         endcase
      end

      s1_in.read_data = rd;
      s1_in.dev       = dev;
      s1_in.taken     = tape_taken;
      s1_in.ipl       = ipl_in;
      s1_in.mode      = mode_in;
      s1_in.motor     = motor_in;
   end

   pidc_tape u_tape (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .sample    (tape_sample),
      .cycle_now (cycle_now),
      .tape_bit  (tape_bit),
      .level     (tape_level),
      .taken     (tape_taken)
   );

   pidc_ram #(
      .WIDTH (8),
      .DEPTH (VRAM_DEPTH)
   ) u_vram (
      .clock   (clock),
      .wr_en   (clr_active_ff || ram_we),
      .wr_addr (clr_active_ff ? clr_addr_ff : vram_idx),
      .wr_data (clr_active_ff ? 8'd0 : wdata),
      .rd_en   (ram_re),
      .rd_addr (vram_idx),
      .rd_data (ram_rdata)
   );

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         ipl_ff        <= 1'b1;
         mode_ff       <= 8'd0;
         motor_ff      <= 1'b0;
         pulse_ff      <= 1'b0;
         psg_ff        <= 8'd0;
         for (int i = 0; i < KEY_ROWS; i++) begin
            key_ff[i] <= KEY_ROW_RST;
         end
         clr_active_ff <= 1'b1;
         clr_addr_ff   <= '0;
         s1_valid_ff   <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         ipl_ff   <= ipl_in;
         mode_ff  <= mode_in;
         motor_ff <= motor_in;
         pulse_ff <= pulse_in;
         psg_ff   <= psg_in;
         key_ff   <= key_in;
         if (clr_active_ff) begin
            if (clr_addr_ff == VRAM_LAST) begin
               clr_active_ff <= 1'b0;
            end else begin
               clr_addr_ff <= clr_addr_ff + VRAM_AW'(1);
            end
         end
         if (acc) begin
            s1_valid_ff <= 1'b1;
         end else if (out_load) begin
            s1_valid_ff <= 1'b0;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Merge the VRAM read data into the pending beat
   always_comb begin
      rsp_in = s1_ff;
      if (s1_use_ram_ff) begin
         rsp_in.read_data = ram_rdata;
      end
   end

   // Payload
   always_ff @(posedge clock) begin
      if (acc) begin
         s1_ff         <= s1_in;
         s1_use_ram_ff <= use_ram;
      end
      if (out_load) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.dev;
   assign rsp_tdata  = {5'd0, rsp_ff.motor, rsp_ff.mode, rsp_ff.ipl, rsp_ff.taken,
                        rsp_ff.read_data};

   // Hold the request side off for the whole clearing pass
   a_no_accept_while_clearing: assert property (
      @(posedge clock) disable iff (reset)
      clr_active_ff |-> !req_tready
   ) else $error("request beat accepted during VRAM clearing pass");

   // Flip the IPL switch on every IPL page access
   a_ipl_flips: assert property (
      @(posedge clock) disable iff (reset)
      (acc && is_ipl && (cmd == CMD_WRITE || cmd == CMD_READ) && !is_key)
         |=> ipl_ff != $past(ipl_ff)
   ) else $error("IPL switch did not flip on access");

   // Change the motor only through a motor page write while the tape runs
   a_motor_source: assert property (
      @(posedge clock) disable iff (reset)
      (!$past(reset) && motor_ff != $past(motor_ff))
         |-> $past(acc && cmd == CMD_WRITE && is_motor && !cfg_ff.tape_stopped)
   ) else $error("motor latch changed without a motor write");

   // Consume a tape bit only on a local status read with the motor on
   a_taken_context: assert property (
      @(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.taken) |-> (rsp_ff.dev == DEV_LOCAL && rsp_ff.motor)
   ) else $error("tape bit taken outside a status read");

endmodule

// ----- sv/pidc_ram.sv -----
// Generic single-clock RAM: one write port, one read port with registered read data.
// No package dependencies.
module pidc_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- sv/pidc_tape.sv -----
// Cassette bit timer: tracks the time of the last tape bit and forms the waveform level.
// Depends on pidc_pkg for the configuration struct.
module pidc_tape
   import pidc_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  cfg_type     cfg,
   input  logic        sample,
   input  logic [31:0] cycle_now,
   input  logic        tape_bit,
   output logic        level,
   output logic        taken
);

   logic [31:0] last_time_ff, last_time_in;
   logic [15:0] period_ff, period_in;
   logic        bit_ff, bit_in;

   logic [31:0] elapsed;
   logic        due;
   logic        cur_bit;
   logic [15:0] threshold;

   always_comb begin
      elapsed   = cycle_now - last_time_ff;
      due       = elapsed >= {16'd0, period_ff};
      // level follows the bit after a possible reload, timed on the old elapsed value
      cur_bit   = due ? tape_bit : bit_ff;
      threshold = cur_bit ? cfg.short_tone : {1'b0, cfg.short_tone[15:1]};
      level     = elapsed < {16'd0, threshold};
      taken     = sample && due;

      last_time_in = last_time_ff;
      period_in    = period_ff;
      bit_in       = bit_ff;
      if (taken) begin
         last_time_in = cycle_now;
         bit_in       = tape_bit;
         period_in    = tape_bit ? cfg.one_period : cfg.zero_period;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         last_time_ff <= '0;
         period_ff    <= '0;
         bit_ff       <= 1'b0;
      end else begin
         last_time_ff <= last_time_in;
         period_ff    <= period_in;
         bit_ff       <= bit_in;
      end
   end

endmodule

// ----- tb/pidc_port_checker.sv -----
// Checker for the port decoder: tracks register writes, predicts each response beat
// from the request beats and compares them in order. Depends on pidc_pkg.
module pidc_port_checker
   import pidc_pkg::*;
#(
   parameter int VRAM_DEPTH = VRAM_DEPTH_DEF,
   parameter int KEY_ROWS   = KEY_ROWS_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [1:0]  req_tuser,
   input  logic [63:0] req_tdata,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [2:0]  rsp_tuser,
   input  logic [23:0] rsp_tdata,
   input  logic        csr_wr_en,
   input  logic [1:0]  csr_index,
   input  logic [15:0] csr_wdata,
   output int          errors,
   output int          pending
);

   typedef struct packed {
      logic [7:0] read_data;
      logic [2:0] device;
      logic       tape_taken;
      logic       ipl;
      logic [7:0] mode;
      logic       motor;
   } reply_type;

   logic [7:0]  vram_copy [VRAM_DEPTH];
   logic [7:0]  key_matrix [KEY_ROWS];
   logic [7:0]  mode_copy;
   logic [7:0]  psg_select;
   logic        ipl_copy;
   logic        motor_copy;
   logic        motor_armed;
   logic        wave_bit;
   logic [31:0] bit_stamp;
   logic [15:0] bit_length;
   cfg_type     cfg;
   reply_type   replies_due [$];
   int          reported;

   // Status read of the cassette: consume the offered bit once the current one is over,
   // then judge the level on the elapsed count from before the update.
   task automatic read_cassette(input logic [31:0] now, input logic offered,
                                output logic [7:0] status, inout logic taken);
      logic [31:0] elapsed;
      logic        high;
      elapsed = now - bit_stamp;
      if (elapsed >= {16'd0, bit_length}) begin
         wave_bit   = offered;
         bit_stamp  = now;
         bit_length = offered ? cfg.one_period : cfg.zero_period;
         taken      = 1'b1;
      end
      high   = wave_bit ? (elapsed < {16'd0, cfg.short_tone})
                        : (elapsed < {17'd0, cfg.short_tone[15:1]});
      status = high ? (STATUS_BASE | STATUS_TAPE) : STATUS_BASE;
   endtask

   task automatic decode_access(input logic [1:0] cmd, input logic [63:0] beat,
                                output reply_type r);
      logic [15:0] port;
      logic [7:0]  data;
      logic [3:0]  row;
      logic [31:0] now;
      logic        offered;
      port    = beat[15:0];
      data    = beat[23:16];
      row     = beat[27:24];
      now     = beat[59:28];
      offered = beat[60];
      r       = '0;
      case (cmd)
         CMD_WRITE: begin
            if ((port & PAGE_MASK) == PAGE_VRAM) begin
               vram_copy[port % VRAM_DEPTH] = data;
            end else if ((port & PAGE_MASK) == PAGE_IPL) begin
               ipl_copy = !ipl_copy;
            end else if ((port & PAGE_MASK) == PAGE_MODE) begin
               mode_copy = data;
            end else if ((port & VDP_MASK) == VDP_MASK) begin
               r.device = port[0] ? DEV_VDP1 : DEV_VDP0;
            end else if ((port & PAGE_MASK) == PAGE_MOTOR) begin
               // motor toggles on a falling pulse of the motor bit
               if (!cfg.tape_stopped) begin
                  if ((data & MOTOR_BIT) != 8'h00) begin
                     motor_armed = 1'b1;
                  end else if (motor_armed) begin
                     motor_armed = 1'b0;
                     motor_copy  = !motor_copy;
                  end
               end
            end else if ((port & PSG_MASK) == PSG_PORT) begin
               if (port[0]) begin
                  r.device = DEV_PSG_WRITE;
               end else begin
                  psg_select = data;
                  r.device   = DEV_PSG_SEL;
               end
            end
         end
         CMD_READ: begin
            if (port >= KEY_PORT_BASE && port <= KEY_PORT_LAST) begin
               r.read_data = (port[3:0] < KEY_ROWS) ? key_matrix[port[3:0]] : KEY_ROW_RST;
            end else if ((port & PAGE_MASK) == PAGE_IPL) begin
               ipl_copy = !ipl_copy;
            end else if ((port & PAGE_MASK) == PAGE_MODE) begin
               r.read_data = mode_copy;
            end else if ((port & PAGE_MASK) == PAGE_VRAM) begin
               r.read_data = vram_copy[port % VRAM_DEPTH];
            end else if ((port & VDP_MASK) == VDP_MASK) begin
               r.device = port[0] ? DEV_VDP1 : DEV_VDP0;
            end else if ((port & PSG_MASK) == PSG_PORT) begin
               r.read_data = STATUS_BASE;
               if (port[0]) begin
                  if (psg_select != PSG_STATUS_REG) begin
                     r.device    = DEV_PSG_READ;
                     r.read_data = 8'h00;
                  end else if (motor_copy) begin
                     read_cassette(now, offered, r.read_data, r.tape_taken);
                  end else begin
                     r.read_data = STATUS_BASE | STATUS_MOTOR;
                  end
               end
            end
         end
         CMD_KEY_ROW: begin
            if (row < KEY_ROWS) key_matrix[row] = data;
         end
         default: ;
      endcase
      r.ipl   = ipl_copy;
      r.mode  = mode_copy;
      r.motor = motor_copy;
   endtask

   always @(posedge clock) begin
      reply_type want;
      reply_type got;
      if (reset) begin
         for (int i = 0; i < VRAM_DEPTH; i++) vram_copy[i] = 8'h00;
         for (int i = 0; i < KEY_ROWS; i++) key_matrix[i] = KEY_ROW_RST;
         mode_copy   = 8'h00;
         psg_select  = 8'h00;
         ipl_copy    = 1'b1;
         motor_copy  = 1'b0;
         motor_armed = 1'b0;
         wave_bit    = 1'b0;
         bit_stamp   = 32'd0;
         bit_length  = 16'd0;
         cfg         = '{1'b0, SHORT_TONE_RST, ZERO_PERIOD_RST, ONE_PERIOD_RST};
         errors      = 0;
         reported    = 0;
         replies_due.delete();
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_TAPE_STOPPED: cfg.tape_stopped = csr_wdata[0];
               CSR_SHORT_TONE:   cfg.short_tone   = csr_wdata;
               CSR_ZERO_PERIOD:  cfg.zero_period  = csr_wdata;
               CSR_ONE_PERIOD:   cfg.one_period   = csr_wdata;
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            decode_access(req_tuser, req_tdata, want);
            replies_due.push_back(want);
         end
         if (rsp_tvalid && rsp_tready) begin
            got = '{rsp_tdata[7:0], rsp_tuser, rsp_tdata[8], rsp_tdata[9],
                    rsp_tdata[17:10], rsp_tdata[18]};
            if (replies_due.size() == 0) begin
               errors++;
               if (reported < 10) begin
                  reported++;
                  $display("unexpected response beat: rd=%h dev=%0d tk=%b ipl=%b mode=%h mot=%b",
                           got.read_data, got.device, got.tape_taken, got.ipl, got.mode,
                           got.motor);
               end
            end else begin
               want = replies_due.pop_front();
               if (got !== want) begin
                  errors++;
                  if (reported < 10) begin
                     reported++;
                     $display("mismatch: expected rd=%h dev=%0d tk=%b ipl=%b mode=%h mot=%b",
                              want.read_data, want.device, want.tape_taken, want.ipl,
                              want.mode, want.motor);
                     $display("          actual   rd=%h dev=%0d tk=%b ipl=%b mode=%h mot=%b",
                              got.read_data, got.device, got.tape_taken, got.ipl, got.mode,
                              got.motor);
                  end
               end
            end
         end
      end
      pending = replies_due.size();
   end

endmodule

// ----- tb/tb_port_io_decoder_cassette.sv -----
// Testbench top of the port decoder: clock, reset, request and register stimulus,
// response back-pressure and the verdict. Depends on pidc_pkg and pidc_port_checker.
module tb_port_io_decoder_cassette;
   import pidc_pkg::*;

   localparam logic [1:0] CMD_UNUSED  = 2'd3;
   localparam int         STALL_LIMIT = 50000;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [1:0]  req_tuser;    // [1:0] command
   logic [63:0] req_tdata;    // port, write_data, key_row, cycle_now, tape_bit, zero pad
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [2:0]  rsp_tuser;    // [2:0] device_select
   logic [23:0] rsp_tdata;    // read_data, tape_bit_taken, ipl_enabled, graphics_mode,
                              // motor_on, zero pad
   logic        csr_wr_en;
   logic [1:0]  csr_index;
   logic [15:0] csr_wdata;

   int          watch_errors;
   int          watch_pending;
   int          send_idle;
   int          recv_idle;
   int          stall_cycles = 0;
   logic [31:0] cpu_cycle;
   logic [15:0] tone_len;
   logic [15:0] one_len;

   port_io_decoder_cassette uut (.*);

   pidc_port_checker watch (
      .clock, .reset,
      .req_tvalid, .req_tready, .req_tuser, .req_tdata,
      .rsp_tvalid, .rsp_tready, .rsp_tuser, .rsp_tdata,
      .csr_wr_en, .csr_index, .csr_wdata,
      .errors(watch_errors), .pending(watch_pending)
   );

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   always @(negedge clock) begin
      rsp_tready = ($urandom_range(0, 99) >= recv_idle);
   end

   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("tb_port_io_decoder_cassette: done, errors");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   // Called at a falling edge; returns at the falling edge after the beat is taken.
   task automatic send_access(input logic [1:0] cmd, input logic [15:0] port,
                              input logic [7:0] data, input logic [3:0] row,
                              input logic offered);
      while ($urandom_range(0, 99) < send_idle) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = cmd;
      req_tdata  = {3'b000, offered, cpu_cycle, row, data, port};
      do @(posedge clock); while (!req_tready);
      @(negedge clock);
   endtask

   // Hold the request side until every response is back, then rewrite all registers.
   task automatic configure(input logic stopped, input logic [15:0] tone,
                            input logic [15:0] zero_len, input logic [15:0] one_bit_len);
      req_tvalid = 1'b0;
      while (watch_pending != 0) @(negedge clock);
      csr_wr_en = 1'b1;
      csr_index = CSR_TAPE_STOPPED;
      csr_wdata = {15'd0, stopped};
      @(negedge clock);
      csr_index = CSR_SHORT_TONE;
      csr_wdata = tone;
      @(negedge clock);
      csr_index = CSR_ZERO_PERIOD;
      csr_wdata = zero_len;
      @(negedge clock);
      csr_index = CSR_ONE_PERIOD;
      csr_wdata = one_bit_len;
      @(negedge clock);
      csr_wr_en = 1'b0;
      tone_len  = tone;
      one_len   = one_bit_len;
   endtask

   task automatic random_access();
      int          pick;
      int          step;
      logic [1:0]  cmd;
      logic [15:0] port;
      logic [7:0]  data;
      logic [3:0]  row;
      pick = $urandom_range(0, 99);
      step = $urandom_range(0, 99);
      cmd  = CMD_READ;
      port = 16'h0000;
      data = 8'($urandom);
      row  = 4'($urandom);
      // walk the cycle count mostly within one tone so the waveform is seen at both levels
      if (step < 60) cpu_cycle += $urandom_range(0, tone_len);
      else if (step < 92) cpu_cycle += $urandom_range(0, 2 * one_len);
      else cpu_cycle = $urandom;
      if (pick < 28) begin
         port = (pick < 24) ? (PSG_PORT | 16'h0001) : PSG_PORT;
      end else if (pick < 36) begin
         cmd  = CMD_WRITE;
         port = PSG_PORT;
         if ($urandom_range(0, 4) != 0) data = PSG_STATUS_REG;
      end else if (pick < 46) begin
         cmd  = CMD_WRITE;
         port = PAGE_MOTOR | 16'($urandom_range(0, 16'h1FFF));
      end else if (pick < 66) begin
         cmd  = (pick < 56) ? CMD_WRITE : CMD_READ;
         port = $urandom_range(0, 1) ? 16'($urandom_range(0, 31))
                                     : 16'($urandom_range(0, VRAM_DEPTH_DEF - 1));
      end else if (pick < 71) begin
         cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
         port = PAGE_MODE | 16'($urandom_range(0, 16'h1FFF));
      end else if (pick < 76) begin
         cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
         port = PAGE_IPL | 16'($urandom_range(0, 16'h1FFF));
      end else if (pick < 80) begin
         cmd = CMD_KEY_ROW;
         if ($urandom_range(0, 3) != 0) row = 4'($urandom_range(0, 9));
      end else if (pick < 84) begin
         port = KEY_PORT_BASE + 16'($urandom_range(0, 9));
      end else if (pick < 89) begin
         cmd  = $urandom_range(0, 1) ? CMD_WRITE : CMD_READ;
         port = VDP_MASK | 16'($urandom);
      end else if (pick < 96) begin
         cmd  = 2'($urandom);
         port = 16'($urandom);
      end else begin
         cmd  = CMD_UNUSED;
         port = 16'($urandom);
      end
      send_access(cmd, port, data, row, 1'($urandom));
   endtask

   initial begin
      reset      = 1'b1;
      req_tvalid = 1'b0;
      req_tuser  = CMD_WRITE;
      req_tdata  = 64'd0;
      rsp_tready = 1'b0;
      csr_wr_en  = 1'b0;
      csr_index  = CSR_TAPE_STOPPED;
      csr_wdata  = 16'd0;
      cpu_cycle  = 32'd0;
      tone_len   = SHORT_TONE_RST;
      one_len    = ONE_PERIOD_RST;
      send_idle  = 22;
      recv_idle  = 56;
      repeat (11) @(negedge clock);
      reset = 1'b0;

      // directed: status byte paths, motor pulse, tape bits across the count wrap
      send_access(CMD_READ, PSG_PORT | 16'h0001, 8'h00, 4'h0, 1'b0);
      send_access(CMD_WRITE, PSG_PORT, PSG_STATUS_REG, 4'h0, 1'b0);
      send_access(CMD_READ, PSG_PORT | 16'h0001, 8'h00, 4'h0, 1'b1);
      send_access(CMD_READ, PSG_PORT, 8'h00, 4'h0, 1'b1);
      send_access(CMD_WRITE, PAGE_MOTOR, MOTOR_BIT, 4'h0, 1'b0);
      send_access(CMD_WRITE, PAGE_MOTOR | 16'h1FFF, 8'hFD, 4'h0, 1'b0);
      send_access(CMD_READ, PSG_PORT | 16'h0001, 8'h00, 4'h0, 1'b1);
      cpu_cycle = 32'd1000;
      send_access(CMD_READ, PSG_PORT | 16'h0001, 8'h00, 4'h0, 1'b0);
      cpu_cycle = 32'd2000;
      send_access(CMD_READ, PSG_PORT | 16'h0001, 8'h00, 4'h0, 1'b0);
      cpu_cycle = 32'hFFFF_FFFF;
      send_access(CMD_READ, PSG_PORT | 16'h0001, 8'h00, 4'h0, 1'b0);
      cpu_cycle = 32'h0000_0100;
      send_access(CMD_READ, PSG_PORT | 16'h0001, 8'h00, 4'h0, 1'b1);
      // video RAM ends, mode latch, IPL switch
      send_access(CMD_WRITE, 16'h0000, 8'hFF, 4'h0, 1'b0);
      send_access(CMD_WRITE, 16'h1FFF, 8'hA5, 4'h0, 1'b0);
      send_access(CMD_READ, 16'h1FFF, 8'h00, 4'h0, 1'b0);
      send_access(CMD_READ, 16'h0000, 8'h00, 4'h0, 1'b0);
      send_access(CMD_WRITE, PAGE_MODE, 8'hFF, 4'h0, 1'b0);
      send_access(CMD_READ, 16'h3FFF, 8'h00, 4'h0, 1'b0);
      send_access(CMD_WRITE, PAGE_IPL, 8'h00, 4'h0, 1'b0);
      send_access(CMD_READ, 16'hBFFF, 8'h00, 4'h0, 1'b0);
      // keyboard rows, including a row index past the matrix
      send_access(CMD_KEY_ROW, 16'h0000, 8'h00, 4'd9, 1'b0);
      send_access(CMD_KEY_ROW, 16'hFFFF, 8'h12, 4'hF, 1'b1);
      send_access(CMD_READ, KEY_PORT_LAST, 8'h00, 4'h0, 1'b0);
      send_access(CMD_READ, KEY_PORT_BASE, 8'h00, 4'h0, 1'b0);
      // outside chips, unmapped read, unknown command
      send_access(CMD_WRITE, VDP_MASK, 8'h55, 4'h0, 1'b0);
      send_access(CMD_READ, 16'hFFFF, 8'h00, 4'h0, 1'b0);
      send_access(CMD_WRITE, PSG_PORT | 16'h0001, 8'h77, 4'h0, 1'b0);
      send_access(CMD_READ, PAGE_MOTOR, 8'h00, 4'h0, 1'b0);
      send_access(CMD_UNUSED, 16'hFFFF, 8'hFF, 4'hF, 1'b1);

      for (int seg = 0; seg < 6; seg++) begin
         case (seg)
            0: configure(1'b0, SHORT_TONE_RST, ZERO_PERIOD_RST, ONE_PERIOD_RST);
            1: configure(1'b0, 16'd1, 16'd1, 16'd1);
            2: configure(1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
            3: configure(1'($urandom), 16'($urandom_range(1, 4000)),
                         16'($urandom_range(1, 4000)), 16'($urandom_range(1, 4000)));
            4: configure(1'b0, 16'd200, 16'd100, 16'd300);
            default: configure(1'b0, 16'($urandom_range(1, 65535)),
                               16'($urandom_range(1, 65535)), 16'($urandom_range(1, 65535)));
         endcase
         if (seg < 2) begin
            send_idle = 22;
            recv_idle = 56;
         end else if (seg < 4) begin
            send_idle = 56;
            recv_idle = 22;
         end else begin
            send_idle = 0;
            recv_idle = 0;
         end
         repeat (315) random_access();
      end

      req_tvalid = 1'b0;
      while (watch_pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
      if (watch_errors == 0) begin
         $display("tb_port_io_decoder_cassette: done, clean");
      end else begin
         $display("tb_port_io_decoder_cassette: done, errors");
      end
      $finish;
   end

endmodule
